/* src/u2u8_pkg.sv */
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

    // Unit classification masks and patterns
    localparam logic [15:0] MASK_ASCII   = 16'hFF80;
    localparam logic [15:0] MASK_TWO     = 16'hF800;
    localparam logic [15:0] MASK_SURR    = 16'hFC00;
    localparam logic [15:0] HIGH_SURR    = 16'hD800;
    localparam logic [15:0] LOW_SURR     = 16'hDC00;

    // UTF-8 lead and continuation marks
    localparam logic [7:0]  LEAD_TWO     = 8'hC0;
    localparam logic [7:0]  LEAD_THREE   = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR    = 8'hF0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;
    localparam logic [5:0]  CONT_BITS    = 6'h3F;

    // Most bytes one item can cause
    localparam int unsigned MAX_BYTES    = 6;
    localparam int unsigned IDX_W        = $clog2(MAX_BYTES);
    localparam int unsigned CNT_W        = $clog2(MAX_BYTES + 1);

    // One encoding job: bytes in output order, index 0 first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } job_t;

    // Continuation byte from the low six bits
    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        cont_byte = CONT_MARK | {2'b00, bits & CONT_BITS};
    endfunction

endpackage

/* src/u2u8_front.sv */
// ----------------------------------------------------------------------------
// u2u8_front
// Classifies each code unit, keeps the pending high surrogate and builds the
// byte job for the back end.
// ----------------------------------------------------------------------------
module u2u8_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [15:0]         code_unit,
    output u2u8_pkg::job_t      job,
    output logic                job_wr
);
    import u2u8_pkg::*;

    logic [9:0]  held_bits_reg;
    logic [9:0]  held_bits_next;
    logic        held_valid_reg;
    logic        held_valid_next;

    logic        is_pair;
    logic        is_high;
    logic [20:0] code_point;
    logic [15:0] held_unit;
    logic [2:0][7:0] pre_bytes;
    logic [2:0][7:0] own_bytes;
    logic [CNT_W-1:0] own_count;

    assign is_pair    = held_valid_reg && ((code_unit & MASK_SURR) == LOW_SURR);
    assign is_high    = (code_unit & MASK_SURR) == HIGH_SURR;
    assign code_point = 21'h10000 + {1'b0, held_bits_reg, code_unit[9:0]};
    assign held_unit  = {6'b110110, held_bits_reg};

    // Three-byte form of the broken surrogate that was held
    assign pre_bytes[0] = LEAD_THREE | {4'h0, held_unit[15:12]};
    assign pre_bytes[1] = cont_byte(held_unit[11:6]);
    assign pre_bytes[2] = cont_byte(held_unit[5:0]);

    // Bytes of the new unit on its own
    always_comb
    begin
        own_bytes = '0;
        own_count = '0;
        if (code_unit == 16'h0000)
        begin
            own_count = CNT_W'(1);
        end
        else if ((code_unit & MASK_ASCII) == 16'h0000)
        begin
            own_bytes[0] = code_unit[7:0];
            own_count    = CNT_W'(1);
        end
        else if ((code_unit & MASK_TWO) == 16'h0000)
        begin
            own_bytes[0] = LEAD_TWO | {3'b000, code_unit[10:6]};
            own_bytes[1] = cont_byte(code_unit[5:0]);
            own_count    = CNT_W'(2);
        end
        else if (is_high)
        begin
            own_count = '0;
        end
        else
        begin
            own_bytes[0] = LEAD_THREE | {4'h0, code_unit[15:12]};
            own_bytes[1] = cont_byte(code_unit[11:6]);
            own_bytes[2] = cont_byte(code_unit[5:0]);
            own_count    = CNT_W'(3);
        end
    end

    // Job assembly
    always_comb
    begin
        job = '0;
        if (is_pair)
        begin
            job.bytes[0] = LEAD_FOUR | {5'b00000, code_point[20:18]};
            job.bytes[1] = cont_byte(code_point[17:12]);
            job.bytes[2] = cont_byte(code_point[11:6]);
            job.bytes[3] = cont_byte(code_point[5:0]);
            job.count    = CNT_W'(4);
        end
        else if (held_valid_reg)
        begin
            job.bytes[2:0] = pre_bytes;
            job.bytes[5:3] = own_bytes;
            job.count      = own_count + CNT_W'(3);
        end
        else
        begin
            job.bytes[2:0] = own_bytes;
            job.count      = own_count;
        end
    end

    assign job_wr = accept && (job.count != '0);

    // Held surrogate update
    always_comb
    begin
        held_bits_next  = held_bits_reg;
        held_valid_next = held_valid_reg;
        if (accept)
        begin
            if (!is_pair && is_high)
            begin
                held_bits_next  = code_unit[9:0];
                held_valid_next = 1'b1;
            end
            else
            begin
                held_bits_next  = '0;
                held_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bits_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_bits_reg  <= held_bits_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

/* src/u2u8_fifo.sv */
// ----------------------------------------------------------------------------
// u2u8_fifo
// Short job queue between the front end and the byte serialiser.
// ----------------------------------------------------------------------------
module u2u8_fifo
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  u2u8_pkg::job_t      wr_job,
    input  logic                rd,
    output u2u8_pkg::job_t      rd_job,
    output logic                full,
    output logic                empty
);
    import u2u8_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LVL_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;

    assign full   = level_reg == LVL_W'(DEPTH);
    assign empty  = level_reg == '0;
    assign rd_job = slots_reg[rd_ptr_reg];

    // Pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

/* src/u2u8_back.sv */
// ----------------------------------------------------------------------------
// u2u8_back
// Takes jobs from the queue and hands out their bytes through an output
// register, one per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module u2u8_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  u2u8_pkg::job_t      job,
    input  logic                job_empty,
    output logic                job_rd,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic                last_of_run
);
    import u2u8_pkg::*;

    job_t             cur_reg;
    job_t             cur_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             busy_reg;
    logic             busy_next;
    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic             last_reg;
    logic             last_next;
    logic             valid_reg;
    logic             valid_next;

    logic             can_load;
    logic             at_last;

    assign can_load = !valid_reg || pop;
    assign at_last  = (CNT_W'(idx_reg) + 1'b1) == cur_reg.count;
    assign job_rd   = !job_empty && (!busy_reg || (can_load && at_last));

    // Serialiser and output register
    always_comb
    begin
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b0;
        end
        if (busy_reg && can_load)
        begin
            byte_next  = cur_reg.bytes[idx_reg];
            last_next  = at_last;
            valid_next = 1'b1;
            idx_next   = idx_reg + 1'b1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (job_rd)
        begin
            cur_next  = job;
            idx_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign empty       = !valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;

endmodule

/* src/utf16_to_utf8_encoder.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing.
// ----------------------------------------------------------------------------
// Each pushed code unit is classified at once and turned into a job of 0 to 6
// bytes; jobs wait in a queue of JOB_DEPTH entries and a serialiser delivers
// one byte per cycle from its output register while pop keeps it drained. A
// unit causes 1 byte for ASCII and the terminating zero, 2 or 3 for other BMP
// units, 4 for a surrogate pair, up to 6 when a held high surrogate is broken,
// none for a high surrogate that is only held. The single-byte output register
// sets the byte rate. A new unit is taken in every cycle while the queue has
// room; its bytes pass a queue slot, the serialiser's job register and the
// output register before they show on the result ports. last_of_run marks the
// final byte caused by a unit.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder
#(
    parameter int unsigned JOB_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last_of_run
);
    import u2u8_pkg::*;

    logic  accept;
    job_t  front_job;
    logic  job_wr;
    job_t  queue_job;
    logic  job_rd;
    logic  queue_empty;

    assign accept = push && !full;

    u2u8_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_unit (code_unit),
        .job       (front_job),
        .job_wr    (job_wr)
    );

    u2u8_fifo #(.DEPTH(JOB_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_wr),
        .wr_job (front_job),
        .rd     (job_rd),
        .rd_job (queue_job),
        .full   (full),
        .empty  (queue_empty)
    );

    u2u8_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (queue_job),
        .job_empty   (queue_empty),
        .job_rd      (job_rd),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // Queue is never written while full
    assert property (@(posedge clk) disable iff (!rst_n) !(job_wr && full))
        else $error("job written into a full queue");

    // Serialiser only takes a job that is there
    assert property (@(posedge clk) disable iff (!rst_n) job_rd |-> !queue_empty)
        else $error("job read from an empty queue");

    // A terminating zero always causes at least one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && code_unit == 16'h0000) |-> job_wr)
        else $error("zero unit produced no job");

endmodule
